// ===== rtl/kmdg_pkg.sv =====
// ----------------------------------------------------------------------------
// kmdg_pkg
// Shared types and constants for the key matrix debounce and ghost filter.
// ----------------------------------------------------------------------------
package kmdg_pkg;

  // Matrix geometry (each at most 8, since keys are numbered row*8+col)
  localparam int unsigned ROWS = 8;
  localparam int unsigned COLS = 8;

  localparam int unsigned MatrixKeys = 64;
  localparam int unsigned NumKeys    = MatrixKeys + 1;
  localparam int unsigned KeyIdxW    = $clog2(NumKeys);

  localparam logic [KeyIdxW-1:0] ExtraKey     = KeyIdxW'(MatrixKeys);
  localparam logic [KeyIdxW-1:0] LastMatrixKey = KeyIdxW'(MatrixKeys - 1);

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgGhostTicks    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDebounceTicks = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgAltAsModifier = 2'd2;

  localparam logic [7:0] GhostTicksRst    = 8'd10;
  localparam logic [7:0] DebounceTicksRst = 8'd25;

  // Key positions that carry modifier bits
  localparam logic [5:0] KeyLeftCtrl  = 6'd2;
  localparam logic [5:0] KeyLeftShift = 6'd11;
  localparam logic [5:0] KeyLeftAlt   = 6'd5;
  localparam logic [5:0] KeyLeftGui   = 6'd52;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASS1,
    ST_PASS2,
    ST_DRAIN,
    ST_FINISH
  } ctrl_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic               load_in;
    logic               clear_acc;
    logic               rd_en;
    logic               rd_pass2;
    logic [KeyIdxW-1:0] rd_addr;
    logic               out_load;
  } kmdg_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_busy;
  } kmdg_status_t;

  function automatic logic [7:0] modifier_of(input logic [5:0] key, input logic alt_en);
    logic [7:0] m;
    m = 8'h00;
    if (key == KeyLeftCtrl) begin
      m = 8'h01;
    end else if (key == KeyLeftShift) begin
      m = 8'h02;
    end else if (key == KeyLeftAlt) begin
      m = alt_en ? 8'h04 : 8'h00;
    end else if (key == KeyLeftGui) begin
      m = 8'h20;
    end
    return m;
  endfunction

endpackage

// ===== rtl/kmdg_ctrl.sv =====
// ----------------------------------------------------------------------------
// kmdg_ctrl
// Sequencer: accepts a scan, walks the key store twice, hands off the result.
// ----------------------------------------------------------------------------
module kmdg_ctrl import kmdg_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic         out_ready_i,
  input  kmdg_status_t status_i,
  output kmdg_cmd_t    cmd_o
);

  ctrl_state_e        state_q, state_d;
  logic [KeyIdxW-1:0] cnt_q, cnt_d;
  logic               out_free;

  assign out_free = !status_i.out_busy || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) begin
          state_d = ST_PASS1;
        end
      end
      ST_PASS1: begin
        // pass 1 includes the extra key as the last entry
        if (cnt_q == ExtraKey) begin
          state_d = ST_PASS2;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_PASS2: begin
        if (cnt_q == LastMatrixKey) begin
          state_d = ST_DRAIN;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_in   = in_valid_i;
        cmd_o.clear_acc = in_valid_i;
      end
      ST_PASS1: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = cnt_q;
      end
      ST_PASS2: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_pass2 = 1'b1;
        cmd_o.rd_addr  = cnt_q;
      end
      ST_DRAIN: begin
      end
      ST_FINISH: begin
        cmd_o.out_load = out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/kmdg_datapath.sv =====
// ----------------------------------------------------------------------------
// kmdg_datapath
// Key state store, per-key update, row/column counts and result registers.
// ----------------------------------------------------------------------------
module kmdg_datapath import kmdg_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  kmdg_cmd_t            cmd_i,
  output kmdg_status_t         status_o,
  input  logic                 cfg_valid_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [7:0]           cfg_data_i,
  input  logic [63:0]          matrix_up_bits_i,
  input  logic                 extra_key_up_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [63:0]          pressed_mask_o,
  output logic [63:0]          pending_mask_o,
  output logic                 extra_key_pressed_o,
  output logic [7:0]           scan_modifiers_o
);

  // Configuration
  logic [7:0] ghost_ticks_q, debounce_ticks_q;
  logic       alt_mod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ghost_ticks_q    <= GhostTicksRst;
      debounce_ticks_q <= DebounceTicksRst;
      alt_mod_q        <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgGhostTicks:    ghost_ticks_q    <= cfg_data_i;
        CfgDebounceTicks: debounce_ticks_q <= cfg_data_i;
        CfgAltAsModifier: alt_mod_q        <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  logic [7:0] press_load;
  assign press_load = (ghost_ticks_q == 8'hFF) ? 8'hFF : ghost_ticks_q + 8'd1;

  // Captured scan
  logic [63:0] up_q;
  logic        extra_up_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      up_q       <= matrix_up_bits_i;
      extra_up_q <= extra_key_up_i;
    end
  end

  // Key store: {status, debounce}; entries read as zero until first written
  logic [15:0]        key_mem [NumKeys];
  logic [NumKeys-1:0] entry_vld_q;
  logic [15:0]        rd_data_q;
  logic               rd_vld_q;
  logic               wr_en;
  logic [15:0]        wr_data;

  // Processing stage, in the cycle after the read is issued
  logic               proc_v_q, proc_pass2_q;
  logic [KeyIdxW-1:0] proc_k_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[proc_k_q] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= key_mem[cmd_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_vld_q  <= '0;
      rd_vld_q     <= 1'b0;
      proc_v_q     <= 1'b0;
      proc_pass2_q <= 1'b0;
      proc_k_q     <= '0;
    end else begin
      if (wr_en) begin
        entry_vld_q[proc_k_q] <= 1'b1;
      end
      if (cmd_i.rd_en) begin
        rd_vld_q <= entry_vld_q[cmd_i.rd_addr];
      end
      proc_v_q     <= cmd_i.rd_en;
      proc_pass2_q <= cmd_i.rd_pass2;
      proc_k_q     <= cmd_i.rd_addr;
    end
  end

  logic [7:0] st_r, db_r;
  logic [2:0] k_row, k_col;
  logic       is_extra, in_matrix;

  assign st_r     = rd_vld_q ? rd_data_q[15:8] : 8'd0;
  assign db_r     = rd_vld_q ? rd_data_q[7:0]  : 8'd0;
  assign k_row    = proc_k_q[5:3];
  assign k_col    = proc_k_q[2:0];
  assign is_extra = proc_k_q[KeyIdxW-1];
  assign in_matrix = !is_extra && (4'(k_row) < 4'(ROWS)) && (4'(k_col) < 4'(COLS));

  // Pass 1: debounce update
  logic [7:0] db_dec, st1, db1;
  logic       up_bit;

  assign up_bit = is_extra ? extra_up_q : up_q[proc_k_q[5:0]];
  assign db_dec = (db_r != 8'd0) ? db_r - 8'd1 : 8'd0;

  always_comb begin
    st1 = st_r;
    db1 = db_dec;
    if (up_bit) begin
      if (db_dec == 8'd0) begin
        st1 = 8'd0;
      end
    end else if (st_r == 8'd0) begin
      st1 = press_load;
      db1 = debounce_ticks_q;
    end
    // extra key has no ghost test
    if (is_extra && st1 > 8'd1) begin
      st1 = 8'd1;
    end
  end

  // Row/column counts saturate at 2: only "more than one" matters
  logic [1:0] row_pop_q [8];
  logic [1:0] col_pop_q [8];
  logic       ghost;
  logic [7:0] st2;

  assign ghost = (row_pop_q[k_row] == 2'd2) && (col_pop_q[k_col] == 2'd2);

  always_comb begin
    st2 = st_r;
    if (st_r > 8'd1) begin
      if (ghost) begin
        if (db_r != 8'd0) begin
          st2 = press_load;
        end else if (st_r > 8'd2) begin
          st2 = st_r - 8'd1;
        end
      end else begin
        st2 = st_r - 8'd1;
      end
    end
  end

  logic p1_act, p2_act;
  assign p1_act = proc_v_q && !proc_pass2_q && (in_matrix || is_extra);
  assign p2_act = proc_v_q && proc_pass2_q && in_matrix;

  assign wr_en   = p1_act || p2_act;
  assign wr_data = proc_pass2_q ? {st2, db_r} : {st1, db1};

  // Accumulators for the scan in progress
  logic [63:0] pressed_acc_q, pending_acc_q;
  logic [7:0]  mods_acc_q;
  logic        extra_acc_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_acc) begin
      pressed_acc_q <= '0;
      pending_acc_q <= '0;
      mods_acc_q    <= '0;
      extra_acc_q   <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        row_pop_q[i] <= '0;
        col_pop_q[i] <= '0;
      end
    end else if (p1_act) begin
      if (is_extra) begin
        extra_acc_q <= (st1 == 8'd1);
      end else begin
        if (st1 == 8'd1) begin
          mods_acc_q <= mods_acc_q | modifier_of(proc_k_q[5:0], alt_mod_q);
        end
        if (st1 != 8'd0) begin
          if (row_pop_q[k_row] != 2'd2) row_pop_q[k_row] <= row_pop_q[k_row] + 2'd1;
          if (col_pop_q[k_col] != 2'd2) col_pop_q[k_col] <= col_pop_q[k_col] + 2'd1;
        end
      end
    end else if (p2_act) begin
      pressed_acc_q[proc_k_q[5:0]] <= (st2 == 8'd1);
      pending_acc_q[proc_k_q[5:0]] <= (st2 > 8'd1);
    end
  end

  // Output register
  logic        out_valid_q;
  logic [63:0] pressed_q, pending_q;
  logic        extra_q;
  logic [7:0]  mods_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      pressed_q <= pressed_acc_q;
      pending_q <= pending_acc_q;
      extra_q   <= extra_acc_q;
      mods_q    <= mods_acc_q;
    end
  end

  assign status_o.out_busy   = out_valid_q;
  assign out_valid_o         = out_valid_q;
  assign pressed_mask_o      = pressed_q;
  assign pending_mask_o      = pending_q;
  assign extra_key_pressed_o = extra_q;
  assign scan_modifiers_o    = mods_q;

endmodule

// ===== rtl/key_matrix_debounce_ghost_filter_unit.sv =====
// ----------------------------------------------------------------------------
// key_matrix_debounce_ghost_filter_unit
// Debounce and ghost filtering of full key matrix scans.
// ----------------------------------------------------------------------------
// Each accepted scan is walked through the debounce pass (one key per cycle,
// extra key last) and the ghost pass over the 64 matrix keys, then the last
// key is finished and the output register is loaded. The controller then
// returns to idle, so a new scan is taken only once the previous one has
// reached the output register. The pace is set by the key state store, which
// gives one read and one write per cycle. A new scan may be accepted while the
// previous result waits in the output register. A finished result is held
// back until that register frees up. Configuration writes are always taken
// (cfg_ready_o is tied high) and belong between scans.
module key_matrix_debounce_ghost_filter_unit import kmdg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [63:0]        matrix_up_bits_i,
  input  logic               extra_key_up_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [63:0]        pressed_mask_o,
  output logic [63:0]        pending_mask_o,
  output logic               extra_key_pressed_o,
  output logic [7:0]         scan_modifiers_o
);

  kmdg_cmd_t    cmd;
  kmdg_status_t status;

  assign cfg_ready_o = 1'b1;

  kmdg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  kmdg_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .matrix_up_bits_i   (matrix_up_bits_i),
    .extra_key_up_i     (extra_key_up_i),
    .out_ready_i        (out_ready_i),
    .out_valid_o        (out_valid_o),
    .pressed_mask_o     (pressed_mask_o),
    .pending_mask_o     (pending_mask_o),
    .extra_key_pressed_o(extra_key_pressed_o),
    .scan_modifiers_o   (scan_modifiers_o)
  );

endmodule
